/* rtl/lahd_pkg.sv */
// shared constants for the limit alarm with hysteresis and delay
`default_nettype none

package lahd_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_GLOBAL_EN   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_CHANNEL_EN  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_UPPER_LIMIT = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_LOWER_LIMIT = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_UPPER_FAC   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_LOWER_FAC   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_DELAY       = 3'd6;

  // delay register width and the integer bits of the return factors
  localparam int unsigned DelayW   = 20;
  localparam int unsigned FacIntW  = 2;

  // timer slots
  localparam int unsigned NumTimers    = 4;
  localparam int unsigned TMR_OVER_SET  = 0;
  localparam int unsigned TMR_OVER_CLR  = 1;
  localparam int unsigned TMR_UNDER_SET = 2;
  localparam int unsigned TMR_UNDER_CLR = 3;

  // result beat layout, lowest bit first
  localparam int unsigned OutW          = 8;
  localparam int unsigned OUT_OVER      = 0;
  localparam int unsigned OUT_UNDER     = 1;
  localparam int unsigned OUT_OVER_CHG  = 2;
  localparam int unsigned OUT_UNDER_CHG = 3;

endpackage

`default_nettype wire

/* rtl/limit_alarm_with_hysteresis_delay.sv */
// over/under limit alarm with hysteresis and delay timers, one channel
// A sample beat passes through the input register, then the state update writes its result
//   beat into the result register.
// Throughput: one sample per cycle while the result stream is not stalled; the timers and compares are combinational.
// Reset: both alarms off, all timers stopped and zero, enables off, limits and
//   delay zero, return factors 1.0; no clearing pass is needed.
`default_nettype none

module limit_alarm_with_hysteresis_delay #(
  parameter int unsigned COUNT_WIDTH      = 21,
  parameter int unsigned SAMPLE_WIDTH     = 32,
  parameter int unsigned FACTOR_FRAC_BITS = 14,
  localparam int unsigned InW  = ((SAMPLE_WIDTH + 7) / 8) * 8,
  localparam int unsigned CfgW = (SAMPLE_WIDTH > lahd_pkg::DelayW) ?
                                 SAMPLE_WIDTH : lahd_pkg::DelayW
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write port
  input  wire logic                          cfg_we_i,
  input  wire logic [lahd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgW-1:0]               cfg_data_i,
  // sample stream
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [InW-1:0]                s_axis_tdata,  // sample
  // result stream
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [lahd_pkg::OutW-1:0]          m_axis_tdata   // over_alarm, under_alarm,
                                                            // over_changed, under_changed
);
  import lahd_pkg::*;

  localparam int unsigned FacW = FACTOR_FRAC_BITS + FacIntW;
  localparam int unsigned PW   = SAMPLE_WIDTH + FACTOR_FRAC_BITS + 3;
  localparam int unsigned CmpW = (COUNT_WIDTH > DelayW) ? COUNT_WIDTH : DelayW;
  localparam logic [COUNT_WIDTH-1:0] CntMax = {COUNT_WIDTH{1'b1}};

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] cnt;
    logic                   run;
    logic                   fire;
  } tmr_t;

  // configuration registers
  logic                           gen_q, cen_q;
  logic signed [SAMPLE_WIDTH-1:0] up_q, lo_q;
  logic [FacW-1:0]                ufac_q, lfac_q;
  logic [DelayW-1:0]              delay_q;

  // release levels, registered from the limit and factor registers
  logic signed [PW-1:0]           up_rel_q, lo_rel_q;

  // pipeline registers
  logic                           in_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] sample_q;
  logic                           out_valid_q;
  logic [OutW-1:0]                out_data_q, out_data_d;
  logic                           move;

  // alarm and timer state
  logic                           over_q, over_d, under_q, under_d;
  logic [NumTimers-1:0]           run_q, run_d;
  logic [COUNT_WIDTH-1:0]         cnt_q [NumTimers];
  logic [COUNT_WIDTH-1:0]         cnt_d [NumTimers];
  logic [COUNT_WIDTH-1:0]         adv   [NumTimers];

  logic                           en, above, below, rel_over, rel_under;
  logic signed [PW-1:0]           s_scaled;
  logic signed [FacW:0]           ufac_s, lfac_s;
  tmr_t                           t_os, t_oc, t_us, t_uc;

  // start a stopped timer, or report expiry of a running one
  function automatic tmr_t timer_run(input logic run, input logic [COUNT_WIDTH-1:0] cnt,
                                     input logic [DelayW-1:0] dly);
    tmr_t r;
    r.cnt  = cnt;
    r.run  = 1'b1;
    r.fire = 1'b0;
    if (!run) begin
      r.cnt = '0;
    end else if (CmpW'(cnt) > CmpW'(dly)) begin
      r.cnt  = '0;
      r.run  = 1'b0;
      r.fire = 1'b1;
    end
    return r;
  endfunction

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q   <= 1'b0;
      cen_q   <= 1'b0;
      up_q    <= '0;
      lo_q    <= '0;
      ufac_q  <= FacW'(1) << FACTOR_FRAC_BITS;
      lfac_q  <= FacW'(1) << FACTOR_FRAC_BITS;
      delay_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GLOBAL_EN:   gen_q   <= cfg_data_i[0];
        REG_CHANNEL_EN:  cen_q   <= cfg_data_i[0];
        REG_UPPER_LIMIT: up_q    <= cfg_data_i[SAMPLE_WIDTH-1:0];
        REG_LOWER_LIMIT: lo_q    <= cfg_data_i[SAMPLE_WIDTH-1:0];
        REG_UPPER_FAC:   ufac_q  <= cfg_data_i[FacW-1:0];
        REG_LOWER_FAC:   lfac_q  <= cfg_data_i[FacW-1:0];
        REG_DELAY:       delay_q <= cfg_data_i[DelayW-1:0];
        default: ;
      endcase
    end
  end

  // release levels: limit times return factor, exact
  assign ufac_s = $signed({1'b0, ufac_q});
  assign lfac_s = $signed({1'b0, lfac_q});

  always_ff @(posedge clk_i) begin
    up_rel_q <= PW'(up_q) * PW'(ufac_s);
    lo_rel_q <= PW'(lo_q) * PW'(lfac_s);
  end

  // handshake: the state update runs when the result register can take a beat
  assign move          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || move;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      sample_q <= s_axis_tdata[SAMPLE_WIDTH-1:0];
    end
    if (move) begin
      out_data_q <= out_data_d;
    end
  end

  // compares against limits and release levels
  assign en        = gen_q && cen_q;
  assign above     = sample_q > up_q;
  assign below     = sample_q < lo_q;
  assign s_scaled  = PW'(sample_q) <<< FACTOR_FRAC_BITS;
  assign rel_over  = s_scaled <= up_rel_q;
  assign rel_under = s_scaled >= lo_rel_q;

  // running timers advance first, saturating
  always_comb begin
    for (int i = 0; i < NumTimers; i++) begin
      adv[i] = (run_q[i] && cnt_q[i] != CntMax) ? cnt_q[i] + COUNT_WIDTH'(1) : cnt_q[i];
    end
  end

  assign t_os = timer_run(run_q[TMR_OVER_SET],  adv[TMR_OVER_SET],  delay_q);
  assign t_oc = timer_run(run_q[TMR_OVER_CLR],  adv[TMR_OVER_CLR],  delay_q);
  assign t_us = timer_run(run_q[TMR_UNDER_SET], adv[TMR_UNDER_SET], delay_q);
  assign t_uc = timer_run(run_q[TMR_UNDER_CLR], adv[TMR_UNDER_CLR], delay_q);

  // alarm decisions
  always_comb begin
    for (int i = 0; i < NumTimers; i++) begin
      cnt_d[i] = adv[i];
    end
    run_d   = run_q;
    over_d  = over_q;
    under_d = under_q;
    if (!en) begin
      over_d  = 1'b0;
      under_d = 1'b0;
    end else begin
      // over side
      if (above) begin
        cnt_d[TMR_OVER_CLR] = '0;
        run_d[TMR_OVER_CLR] = 1'b0;
        if (!over_q) begin
          cnt_d[TMR_OVER_SET] = t_os.cnt;
          run_d[TMR_OVER_SET] = t_os.run;
          over_d              = t_os.fire;
        end
      end else begin
        cnt_d[TMR_OVER_SET] = '0;
        run_d[TMR_OVER_SET] = 1'b0;
        if (over_q && rel_over) begin
          cnt_d[TMR_OVER_CLR] = t_oc.cnt;
          run_d[TMR_OVER_CLR] = t_oc.run;
          over_d              = !t_oc.fire;
        end
      end
      // under side
      if (below) begin
        cnt_d[TMR_UNDER_CLR] = '0;
        run_d[TMR_UNDER_CLR] = 1'b0;
        if (!under_q) begin
          cnt_d[TMR_UNDER_SET] = t_us.cnt;
          run_d[TMR_UNDER_SET] = t_us.run;
          under_d              = t_us.fire;
        end
      end else begin
        cnt_d[TMR_UNDER_SET] = '0;
        run_d[TMR_UNDER_SET] = 1'b0;
        if (under_q && rel_under) begin
          cnt_d[TMR_UNDER_CLR] = t_uc.cnt;
          run_d[TMR_UNDER_CLR] = t_uc.run;
          under_d              = !t_uc.fire;
        end
      end
    end
  end

  // result beat
  always_comb begin
    out_data_d                = '0;
    out_data_d[OUT_OVER]      = over_d;
    out_data_d[OUT_UNDER]     = under_d;
    out_data_d[OUT_OVER_CHG]  = over_d ^ over_q;
    out_data_d[OUT_UNDER_CHG] = under_d ^ under_q;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      over_q  <= 1'b0;
      under_q <= 1'b0;
      run_q   <= '0;
      for (int i = 0; i < NumTimers; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (move) begin
      over_q  <= over_d;
      under_q <= under_d;
      run_q   <= run_d;
      for (int i = 0; i < NumTimers; i++) begin
        cnt_q[i] <= cnt_d[i];
      end
    end
  end

  // disabled alarms are off after the tick
  a_disabled_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    move && !en |=> !over_q && !under_q)
    else $error("alarm active after a disabled tick");

  // change flags follow the alarm state transitions
  a_over_chg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    move |=> m_axis_tdata[OUT_OVER_CHG] == (over_q != $past(over_q)))
    else $error("over change flag mismatch");

  a_under_chg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    move |=> m_axis_tdata[OUT_UNDER_CHG] == (under_q != $past(under_q)))
    else $error("under change flag mismatch");

  // state holds while no tick is processed
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !move |=> $stable(over_q) && $stable(under_q) && $stable(run_q))
    else $error("alarm state moved without a tick");

endmodule

`default_nettype wire
